/* hw/rtl/utf8_to_utf16_transcoder_core_defines.svh */
// assertion macros used by the transcoder checker
`ifndef UTF8_TO_UTF16_TRANSCODER_CORE_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define U8U16_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define U8U16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/u8u16_pkg.sv */
// shared types and constants of the utf-8 to utf-16 transcoder
package u8u16_pkg;

  localparam int BYTE_W    = 8;
  localparam int UNIT_W    = 16;
  localparam int CP_W      = 21;
  localparam int LEFT_W    = 2;

  // output queue, depth must be a power of two and at least 2
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
  localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 1);

  // lead byte tags
  localparam logic [2:0] LEAD2_TAG = 3'b110;
  localparam logic [3:0] LEAD3_TAG = 4'b1110;
  localparam logic [4:0] LEAD4_TAG = 5'b11110;
  localparam logic [1:0] CONT_TAG  = 2'b10;

  localparam logic [CP_W-1:0]   SUPP_BASE = 21'h10000;
  localparam logic [UNIT_W-1:0] HI_SURR   = 16'hD800;
  localparam logic [UNIT_W-1:0] LO_SURR   = 16'hDC00;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              last_of_run;
  } out_beat_t;

endpackage

/* hw/rtl/u8u16_if.sv */
// valid/ready channels for the transcoder input bytes and output units
interface u8u16_in_if import u8u16_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_in;
  logic              text_end;

  modport source (output valid, output byte_in, output text_end, input ready);
  modport sink   (input valid, input byte_in, input text_end, output ready);
endinterface

interface u8u16_out_if import u8u16_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [UNIT_W-1:0] code_unit;
  logic              last_of_run;

  modport source (output valid, output code_unit, output last_of_run, input ready);
  modport sink   (input valid, input code_unit, input last_of_run, output ready);
endinterface

/* hw/rtl/utf8_to_utf16_transcoder_core.sv */
// utf-8 byte stream to utf-16 code unit transcoder, top level
//
//   channel  dir  beat payload                     handshake
//   in_bus   in   byte_in[7:0], text_end           valid/ready
//   out_bus  out  code_unit[15:0], last_of_run     valid/ready
//
// one input byte per cycle while in_bus.ready is high; a byte is decoded in the cycle
// it is accepted and its units are written to the output queue behind any units already waiting
// the four-entry output queue drains one unit per cycle while out_bus.ready is high; in_bus.ready drops
// only while more than two units wait, so a surrogate pair always fits
// synchronous active-low reset clears decoder state and empties the queue
module utf8_to_utf16_transcoder_core import u8u16_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  u8u16_in_if.sink    in_bus,
  u8u16_out_if.source out_bus
);

  logic [CP_W-1:0]      acc_r, acc_nxt;
  logic [LEFT_W-1:0]    left_r, left_nxt;
  logic                 ok_r, ok_nxt;

  out_beat_t            fifo_r [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_r, wr_nxt;
  logic [OUT_PTR_W-1:0] rd_r, rd_nxt;
  logic [OUT_CNT_W-1:0] cnt_r, cnt_nxt;

  logic                 in_fire, out_fire;
  logic                 emit;
  logic [CP_W-1:0]      cp;
  logic [CP_W-1:0]      supp;
  logic                 pair;
  logic [UNIT_W-1:0]    hi_unit, lo_unit;
  logic [1:0]           push_n;
  logic [BYTE_W-1:0]    b;

  assign in_bus.ready = (cnt_r <= OUT_CNT_W'(OUT_DEPTH - 2));
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign out_bus.valid       = (cnt_r != '0);
  assign out_bus.code_unit   = fifo_r[rd_r].code_unit;
  assign out_bus.last_of_run = fifo_r[rd_r].last_of_run;
  assign out_fire     = out_bus.valid && out_bus.ready;

  assign b = in_bus.byte_in;

  // byte decode
  always_comb begin
    acc_nxt  = acc_r;
    left_nxt = left_r;
    ok_nxt   = ok_r;
    emit     = 1'b0;
    cp       = acc_r;
    if (left_r == '0) begin
      if (!b[7]) begin
        emit = 1'b1;
        cp   = CP_W'(b);
      end else if (b[7:5] == LEAD2_TAG) begin
        acc_nxt  = CP_W'(b[4:0]);
        left_nxt = LEFT_W'(1);
        ok_nxt   = 1'b1;
      end else if (b[7:4] == LEAD3_TAG) begin
        acc_nxt  = CP_W'(b[3:0]);
        left_nxt = LEFT_W'(2);
        ok_nxt   = 1'b1;
      end else if (b[7:3] == LEAD4_TAG) begin
        acc_nxt  = CP_W'(b[2:0]);
        left_nxt = LEFT_W'(3);
        ok_nxt   = 1'b1;
      end
    end else begin
      if (ok_r) begin
        if (b[7:6] != CONT_TAG) begin
          ok_nxt = 1'b0;
        end else begin
          acc_nxt = {acc_r[CP_W-7:0], b[5:0]};
        end
      end
      left_nxt = left_r - LEFT_W'(1);
      if (left_r == LEFT_W'(1)) begin
        emit    = ok_nxt;
        cp      = acc_nxt;
        acc_nxt = '0;
        ok_nxt  = 1'b1;
      end
    end
    if (in_bus.text_end) begin
      acc_nxt  = '0;
      left_nxt = '0;
      ok_nxt   = 1'b1;
    end
  end

  // surrogate split
  assign pair    = (cp >= SUPP_BASE);
  assign supp    = cp - SUPP_BASE;
  assign hi_unit = HI_SURR + UNIT_W'(supp[CP_W-1:10]);
  assign lo_unit = LO_SURR | UNIT_W'(supp[9:0]);
  assign push_n  = (in_fire && emit) ? (pair ? 2'd2 : 2'd1) : 2'd0;

  assign wr_nxt  = wr_r + OUT_PTR_W'(push_n);
  assign rd_nxt  = rd_r + OUT_PTR_W'(out_fire);
  assign cnt_nxt = cnt_r + OUT_CNT_W'(push_n) - OUT_CNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      left_r <= '0;
      ok_r   <= 1'b1;
      wr_r   <= '0;
      rd_r   <= '0;
      cnt_r  <= '0;
    end else begin
      if (in_fire) begin
        acc_r  <= acc_nxt;
        left_r <= left_nxt;
        ok_r   <= ok_nxt;
      end
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      if (pair) begin
        fifo_r[wr_r]                   <= '{code_unit: hi_unit, last_of_run: 1'b0};
        fifo_r[wr_r + OUT_PTR_W'(1)]   <= '{code_unit: lo_unit, last_of_run: 1'b1};
      end else begin
        fifo_r[wr_r] <= '{code_unit: cp[UNIT_W-1:0], last_of_run: 1'b1};
      end
    end
  end

endmodule

/* hw/rtl/u8u16_chk.sv */
// port-level checker for the transcoder, bound to the top level
`include "utf8_to_utf16_transcoder_core_defines.svh"

module u8u16_chk import u8u16_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [UNIT_W-1:0] code_unit,
  input logic              last_of_run
);

  // a stalled output beat stays offered
  `U8U16_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output beat dropped while stalled")

  // input backpressure only while units are queued
  `U8U16_ASSERT_NOW(a_stall_has_data, clk, rst_n, !in_ready, out_valid, "input stalled with empty output")

  // a non-final unit always lies in the surrogate range
  `U8U16_ASSERT_NOW(a_first_is_high, clk, rst_n, out_valid && !last_of_run, code_unit[15:11] == 5'b11011, "non-final unit outside surrogate range")

  // the high unit is followed at once by its low surrogate
  `U8U16_ASSERT_NEXT(a_low_follows, clk, rst_n, out_valid && out_ready && !last_of_run, out_valid && last_of_run && (code_unit[15:10] == 6'b110111), "low surrogate missing after high")

endmodule

bind utf8_to_utf16_transcoder_core u8u16_chk u_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .code_unit   (out_bus.code_unit),
  .last_of_run (out_bus.last_of_run)
);
